// File: rtl/core/mrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrt_pkg
// Shared types and constants of the multibit trie route lookup.
// ----------------------------------------------------------------------------
package mrt_pkg;

  localparam int FIRST_BITS   = 24;
  localparam int STRIDE_BITS  = 8;
  localparam int CHUNK_COUNT  = 256;
  localparam int LEVEL_COUNT  = 14;
  localparam int LEVEL_W      = 4;
  localparam int DEEP_DEPTH   = (LEVEL_COUNT - 1) * CHUNK_COUNT * (1 << STRIDE_BITS);
  localparam int DEEP_AW      = 20;
  localparam int FILTER_BITS  = 24;
  localparam int WORD_W       = 32;
  localparam int HOP_W        = 31;
  localparam int TAG_W        = 24;
  localparam int FENTRY_W     = TAG_W + WORD_W;
  localparam int IN_DATA_W    = 216;
  localparam int OUT_DATA_W   = 32;

  localparam logic [TAG_W-1:0] TAG_EMPTY = 24'hFFFFFF;

  typedef enum logic [1:0] {
    CMD_WRITE_TRIE   = 2'd0,
    CMD_WRITE_FILTER = 2'd1,
    CMD_LOOKUP       = 2'd2,
    CMD_NONE         = 2'd3
  } cmd_t;

  typedef enum logic [0:0] {
    REG_ADDRESS_FAMILY = 1'b0,
    REG_FILTER_ENABLE  = 1'b1
  } reg_idx_t;

endpackage

// File: rtl/core/mrt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrt_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mrt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/multibit_trie_route_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multibit_trie_route_lookup
// Longest-prefix-match lookup over a DIR-24-8 style multibit trie.
// ----------------------------------------------------------------------------
// After reset the block sweeps the first-level table (to zero) and the filter
// table (to empty) one entry per cycle, with s_axis_tready low. Config writes
// are taken at any time. A write item (trie or filter) is written as it is
// accepted. A lookup reads the first level and filter probe together, then
// each deeper level costs one read of the shared deeper-level RAM, walked
// level after level. The result sits in an output register; a new item is
// taken while it waits, and a finished lookup waits for the slot to free.
// ----------------------------------------------------------------------------
module multibit_trie_route_lookup (
  input  logic                     clk,
  input  logic                     rst,
  // config write channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [0:0]               cfg_index,
  input  logic [0:0]               cfg_data,
  // input stream
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // tdata: table_level[3:0], entry_index[27:4], entry_value[59:28],
  //        filter_tag[83:60], address_upper[147:84], address_lower[211:148]
  input  logic [mrt_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // tuser: command[1:0]
  input  logic [1:0]               s_axis_tuser,
  // result stream
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // tdata: next_hop[30:0], zero[31]
  output logic [mrt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: filter_hit[0], index_error[1]
  output logic [1:0]               m_axis_tuser
);

  import mrt_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_LOOK  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state;

  // input fields
  logic [LEVEL_W-1:0] in_level;
  logic [23:0]        in_index;
  logic [WORD_W-1:0]  in_value;
  logic [TAG_W-1:0]   in_tag;
  logic [63:0]        in_upper;
  logic [63:0]        in_lower;
  cmd_t               in_cmd;

  assign in_level = s_axis_tdata[3:0];
  assign in_index = s_axis_tdata[27:4];
  assign in_value = s_axis_tdata[59:28];
  assign in_tag   = s_axis_tdata[83:60];
  assign in_upper = s_axis_tdata[147:84];
  assign in_lower = s_axis_tdata[211:148];
  assign in_cmd   = cmd_t'(s_axis_tuser);

  logic address_family;
  logic filter_enable;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      address_family <= 1'b1;
      filter_enable  <= 1'b0;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_ADDRESS_FAMILY: address_family <= cfg_data[0];
        REG_FILTER_ENABLE:  filter_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic accept;
  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // lookup context
  logic [127:0]       addr;
  logic               is_v4;
  logic               probe;
  logic [LEVEL_W-1:0] lvl;
  logic [TAG_W-1:0]   atag;
  logic [FIRST_BITS-1:0] clr_cnt;
  logic [HOP_W-1:0]   hop;
  logic               hit;
  logic               err;

  // RAM ports
  logic                  first_we, first_re;
  logic [FIRST_BITS-1:0] first_waddr, first_raddr;
  logic [WORD_W-1:0]     first_wdata, first_rdata;
  logic                  deep_we, deep_re;
  logic [DEEP_AW-1:0]    deep_waddr, deep_raddr;
  logic [WORD_W-1:0]     deep_wdata, deep_rdata;
  logic                  filt_we, filt_re;
  logic [FILTER_BITS-1:0] filt_waddr, filt_raddr;
  logic [FENTRY_W-1:0]   filt_wdata, filt_rdata;

  logic clearing;
  logic is_lookup;
  assign clearing  = (state == ST_CLEAR);
  assign is_lookup = accept && (in_cmd == CMD_LOOKUP);

  // writes: clearing sweep or write items
  always_comb begin
    first_we    = 1'b0;
    first_waddr = in_index;
    first_wdata = in_value;
    deep_we     = 1'b0;
    deep_waddr  = {in_level - 4'd1, in_index[15:0]};
    filt_we     = 1'b0;
    filt_waddr  = in_index;
    filt_wdata  = {in_tag, in_value};
    if (clearing) begin
      first_we    = 1'b1;
      first_waddr = clr_cnt;
      first_wdata = '0;
      filt_we     = 1'b1;
      filt_waddr  = clr_cnt;
      filt_wdata  = {TAG_EMPTY, {WORD_W{1'b0}}};
    end else if (accept) begin
      case (in_cmd)
        CMD_WRITE_TRIE: begin
          if (in_level == '0) begin
            first_we = 1'b1;
          end else if (in_level < LEVEL_W'(LEVEL_COUNT) && in_index[23:16] == '0) begin
            deep_we = 1'b1;
          end
        end
        CMD_WRITE_FILTER: filt_we = 1'b1;
        default: ;
      endcase
    end
  end
  assign deep_wdata = in_value;

  // first level and filter probe are read on acceptance
  logic [TAG_W-1:0] in_atag;
  assign in_atag     = in_upper[63:40];
  assign first_re    = is_lookup;
  assign first_raddr = address_family ? in_upper[63:40] : in_lower[31:8];
  assign filt_re     = is_lookup;
  assign filt_raddr  = in_upper[39:16] ^ in_atag;

  // word under examination
  logic [WORD_W-1:0] w;
  logic [WORD_W-1:0] w_neg;
  logic              w_pos;
  logic              fhit;
  logic [3:0]        byte_sel;
  logic [7:0]        next_byte;
  assign w        = (lvl == '0) ? first_rdata : deep_rdata;
  assign w_neg    = '0 - w;
  assign w_pos    = (w != '0) && !w[WORD_W-1];
  assign fhit     = probe && (filt_rdata[FENTRY_W-1:WORD_W] == atag) && (atag != TAG_EMPTY);
  assign byte_sel = 4'd12 - lvl;
  assign next_byte = addr[{byte_sel, 3'b000} +: 8];

  // walk step control
  logic             finish;
  logic [HOP_W-1:0] hop_next;
  logic             hit_next, err_next;
  always_comb begin
    finish     = 1'b0;
    hop_next   = '0;
    hit_next   = 1'b0;
    err_next   = 1'b0;
    deep_re    = 1'b0;
    deep_raddr = {lvl, w[7:0], next_byte};
    if (state == ST_LOOK) begin
      if (fhit) begin
        finish   = 1'b1;
        hop_next = filt_rdata[HOP_W-1:0];
        hit_next = 1'b1;
      end else if (is_v4) begin
        if (lvl != '0 || !w[WORD_W-1]) begin
          finish   = 1'b1;
          hop_next = w[HOP_W-1:0];
        end else if (w_neg[WORD_W-1:8] != '0) begin
          finish   = 1'b1;
          err_next = 1'b1;
        end else begin
          deep_re    = 1'b1;
          deep_raddr = {lvl, w_neg[7:0], addr[7:0]};
        end
      end else begin
        if (lvl == LEVEL_W'(LEVEL_COUNT - 1)) begin
          finish   = 1'b1;
          hop_next = w[HOP_W-1:0];
        end else if (!w_pos) begin
          finish   = 1'b1;
          hop_next = w_neg[HOP_W-1:0];
        end else if (w[WORD_W-1:8] != '0) begin
          finish   = 1'b1;
          err_next = 1'b1;
        end else begin
          deep_re = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_cnt       <= '0;
      m_axis_tvalid <= 1'b0;
      probe         <= 1'b0;
      lvl           <= '0;
    end else begin
      // ST_DONE drives the valid flag itself
      if (m_axis_tvalid && m_axis_tready && state != ST_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (is_lookup) begin
            state <= ST_LOOK;
            lvl   <= '0;
            probe <= address_family && filter_enable;
          end
        end
        ST_LOOK: begin
          probe <= 1'b0;
          if (finish) begin
            state <= ST_DONE;
          end else begin
            lvl <= lvl + 1'b1;
          end
        end
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (is_lookup) begin
      addr  <= {in_upper, in_lower};
      is_v4 <= !address_family;
      atag  <= in_atag;
    end
    if (state == ST_LOOK && finish) begin
      hop <= hop_next;
      hit <= hit_next;
      err <= err_next;
    end
    if (state == ST_DONE && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {1'b0, hop};
      m_axis_tuser <= {err, hit};
    end
  end

  mrt_ram #(.WIDTH(WORD_W), .DEPTH(1 << FIRST_BITS), .ADDR_W(FIRST_BITS)) u_first (
    .clk(clk), .we(first_we), .waddr(first_waddr), .wdata(first_wdata),
    .re(first_re), .raddr(first_raddr), .rdata(first_rdata)
  );

  mrt_ram #(.WIDTH(WORD_W), .DEPTH(DEEP_DEPTH), .ADDR_W(DEEP_AW)) u_deep (
    .clk(clk), .we(deep_we), .waddr(deep_waddr), .wdata(deep_wdata),
    .re(deep_re), .raddr(deep_raddr), .rdata(deep_rdata)
  );

  mrt_ram #(.WIDTH(FENTRY_W), .DEPTH(1 << FILTER_BITS), .ADDR_W(FILTER_BITS)) u_filter (
    .clk(clk), .we(filt_we), .waddr(filt_waddr), .wdata(filt_wdata),
    .re(filt_re), .raddr(filt_raddr), .rdata(filt_rdata)
  );

endmodule
